/* design/ede_pkg.sv */
package ede_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int SYM_W       = 8;
  localparam int OP_W        = 2;
  localparam int DIST_W      = 7;
  localparam int DIST_MAX    = 127;

  // op codes
  localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_START,
    ST_CELL_RD,
    ST_CELL_CALC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic start;
    logic row_start;
    logic cell_read;
    logic cell_calc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic m_zero;
    logic n_zero;
    logic last_col;
    logic last_row;
    logic out_free;
  } status_t;

endpackage

/* design/ede_ctrl.sv */
module ede_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [ede_pkg::OP_W-1:0] in_op,
  input  ede_pkg::status_t         status,
  output ede_pkg::cmd_t            cmd,
  output logic                     in_stall
);

  ede_pkg::state_t state;
  ede_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ede_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ede_pkg::ST_IDLE);
    case (state)
      ede_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            ede_pkg::OP_APPEND_FIRST: begin
              cmd.load_first = 1'b1;
            end
            ede_pkg::OP_APPEND_SECOND: begin
              cmd.load_second = 1'b1;
            end
            ede_pkg::OP_COMPUTE: begin
              cmd.start = 1'b1;
              if (status.m_zero || status.n_zero) begin
                state_next = ede_pkg::ST_FINISH;
              end else begin
                state_next = ede_pkg::ST_ROW_START;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ede_pkg::ST_ROW_START: begin
        cmd.row_start = 1'b1;
        state_next    = ede_pkg::ST_CELL_RD;
      end
      ede_pkg::ST_CELL_RD: begin
        cmd.cell_read = 1'b1;
        state_next    = ede_pkg::ST_CELL_CALC;
      end
      ede_pkg::ST_CELL_CALC: begin
        cmd.cell_calc = 1'b1;
        if (status.last_col) begin
          if (status.last_row) begin
            state_next = ede_pkg::ST_FINISH;
          end else begin
            state_next = ede_pkg::ST_ROW_START;
          end
        end else begin
          state_next = ede_pkg::ST_CELL_RD;
        end
      end
      ede_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ede_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ede_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/ede_datapath.sv */
module ede_datapath #(
  parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ede_pkg::SYM_W-1:0] in_symbol,
  input  ede_pkg::cmd_t             cmd,
  output ede_pkg::status_t          status,
  input  logic                      out_stall,
  output logic                      out_valid,
  output ede_pkg::out_item_t        out_data
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CMP_W = (LEN_W > ede_pkg::DIST_W) ? LEN_W : ede_pkg::DIST_W;

  logic [ede_pkg::SYM_W-1:0] first_mem  [MAX_LEN];
  logic [ede_pkg::SYM_W-1:0] second_mem [MAX_LEN];
  logic [LEN_W-1:0]          cost_mem   [MAX_LEN];

  logic [ede_pkg::SYM_W-1:0] first_rdata;
  logic [ede_pkg::SYM_W-1:0] second_rdata;
  logic [LEN_W-1:0]          cost_rdata;

  logic [LEN_W-1:0] first_len;
  logic [LEN_W-1:0] second_len;
  logic             dropped;

  logic [LEN_W-1:0] row;
  logic [LEN_W-1:0] col;
  logic             first_row;
  logic [LEN_W-1:0] diag;
  logic [LEN_W-1:0] left;

  logic [LEN_W-1:0] row_m1;
  logic [LEN_W-1:0] col_m1;
  logic [LEN_W-1:0] up;
  logic [LEN_W-1:0] min_a;
  logic [LEN_W-1:0] min_b;
  logic [LEN_W-1:0] cost_new;
  logic [LEN_W-1:0] result;
  logic [CMP_W-1:0] result_ext;
  logic [ede_pkg::DIST_W-1:0] result_sat;

  assign row_m1 = row - LEN_W'(1);
  assign col_m1 = col - LEN_W'(1);

  // one cell of the cost row
  assign up       = first_row ? col : cost_rdata;
  assign min_a    = (up < left) ? up : left;
  assign min_b    = (min_a < diag) ? min_a : diag;
  assign cost_new = (first_rdata == second_rdata) ? diag : min_b + LEN_W'(1);

  assign status.m_zero   = (first_len == '0);
  assign status.n_zero   = (second_len == '0);
  assign status.last_col = (col == second_len);
  assign status.last_row = (row == first_len);
  assign status.out_free = !out_valid || !out_stall;

  always_comb begin
    if (first_len == '0) begin
      result = second_len;
    end else if (second_len == '0) begin
      result = first_len;
    end else begin
      result = left;
    end
    result_ext = CMP_W'(result);
    if (result_ext > CMP_W'(ede_pkg::DIST_MAX)) begin
      result_sat = ede_pkg::DIST_W'(ede_pkg::DIST_MAX);
    end else begin
      result_sat = result_ext[ede_pkg::DIST_W-1:0];
    end
  end

  // string and cost memories
  always_ff @(posedge clk) begin
    if (cmd.load_first && (first_len < LEN_W'(MAX_LEN))) begin
      first_mem[first_len[IDX_W-1:0]] <= in_symbol;
    end
    if (cmd.load_second && (second_len < LEN_W'(MAX_LEN))) begin
      second_mem[second_len[IDX_W-1:0]] <= in_symbol;
    end
    if (cmd.row_start) begin
      first_rdata <= first_mem[row_m1[IDX_W-1:0]];
    end
    if (cmd.cell_read) begin
      second_rdata <= second_mem[col_m1[IDX_W-1:0]];
      cost_rdata   <= cost_mem[col_m1[IDX_W-1:0]];
    end
    if (cmd.cell_calc) begin
      cost_mem[col_m1[IDX_W-1:0]] <= cost_new;
    end
  end

  // lengths, overflow flag, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_len  <= '0;
      second_len <= '0;
      dropped    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load_first) begin
        if (first_len < LEN_W'(MAX_LEN)) begin
          first_len <= first_len + LEN_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.load_second) begin
        if (second_len < LEN_W'(MAX_LEN)) begin
          second_len <= second_len + LEN_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (cmd.finish) begin
        first_len  <= '0;
        second_len <= '0;
        dropped    <= 1'b0;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.distance <= result_sat;
      out_data.overflow <= dropped;
    end
  end

  // row and column walk
  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      first_row <= 1'b0;
    end else begin
      if (cmd.start) begin
        row       <= LEN_W'(1);
        col       <= LEN_W'(1);
        first_row <= 1'b1;
      end
      if (cmd.row_start) begin
        col <= LEN_W'(1);
      end
      if (cmd.cell_calc) begin
        if (col == second_len) begin
          row       <= row + LEN_W'(1);
          first_row <= 1'b0;
        end else begin
          col <= col + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_start) begin
      diag <= row_m1;
      left <= row;
    end
    if (cmd.cell_calc) begin
      diag <= up;
      left <= cost_new;
    end
  end

endmodule

/* design/edit_distance_engine_top.sv */
// Levenshtein edit distance engine. Items with op 0 append symbol to the
// first string, op 1 to the second. Bytes past MAX_LEN per string are
// dropped and flagged. An op 2 item computes the edit distance between the
// two strings (unit cost insert, delete and substitute), emits one result
// item with distance and overflow, and clears both strings and the flag;
// op 3 is ignored. The compute walks the dynamic-programming table one row
// of the first string at a time, keeping a single cost row in a memory:
// each row first fetches its byte of the first string, then each cell does
// a registered memory read and then forms the cell and writes it back. The
// input is stalled for the whole compute, including any wait for the
// previous result to be taken. Loads are taken while a result is still
// waiting at the output.
module edit_distance_engine_top #(
  parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ede_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ede_pkg::out_item_t out_data
);

  // command and status between controller and datapath
  ede_pkg::cmd_t    cmd;
  ede_pkg::status_t status;

  // sequencer: decodes items and steps through rows and cells
  ede_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // string memories, cost row, counters and the result register
  ede_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_symbol (in_data.symbol),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/edit_distance_engine_top_test.sv */
`timescale 1ns / 1ps

module edit_distance_engine_top_test;

  localparam int MAX_LEN = ede_pkg::MAX_LEN_DEF;
  // op 3 has no meaning in the block, it must be dropped without a trace
  localparam logic [ede_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 235;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ede_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ede_pkg::out_item_t out_data;

  edit_distance_engine_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // items waiting to be offered, and results the block still owes
  ede_pkg::in_item_t pending_items[$];
  ede_pkg::out_item_t expected_results[$];

  // shadow copy of the strings held inside the block
  logic [ede_pkg::SYM_W-1:0] first_buf[MAX_LEN];
  logic [ede_pkg::SYM_W-1:0] second_buf[MAX_LEN];
  int unsigned first_len = 0;
  int unsigned second_len = 0;
  logic dropped = 1'b0;

  // idling knobs, changed only between phases
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic hold_request = 1'b0;
  int unsigned hold_left = 0;

  int unsigned mismatch_count = 0;
  int unsigned loaded_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // edit distance over the shadow strings, one cost row at a time
  function automatic logic [ede_pkg::DIST_W-1:0] edit_cost();
    int unsigned row[MAX_LEN+1];
    int unsigned diag;
    int unsigned up;
    int unsigned best;
    for (int unsigned j = 0; j <= second_len; j++) row[j] = j;
    for (int unsigned i = 1; i <= first_len; i++) begin
      diag = row[0];
      row[0] = i;
      for (int unsigned j = 1; j <= second_len; j++) begin
        up = row[j];
        if (first_buf[i-1] == second_buf[j-1]) begin
          best = diag;
        end else begin
          // cheapest of delete, insert and substitute, plus one
          best = up;
          if (row[j-1] < best) best = row[j-1];
          if (diag < best) best = diag;
          best = best + 1;
        end
        diag = up;
        row[j] = best;
      end
    end
    best = row[second_len];
    if (best > ede_pkg::DIST_MAX) best = ede_pkg::DIST_MAX;
    return best[ede_pkg::DIST_W-1:0];
  endfunction

  // update the shadow state for one accepted item, queue its result if any
  task automatic track_item(input ede_pkg::in_item_t item);
    ede_pkg::out_item_t res;
    case (item.op)
      ede_pkg::OP_APPEND_FIRST: begin
        if (first_len < MAX_LEN) begin
          first_buf[first_len] = item.symbol;
          first_len = first_len + 1;
        end else begin
          dropped = 1'b1;
        end
      end
      ede_pkg::OP_APPEND_SECOND: begin
        if (second_len < MAX_LEN) begin
          second_buf[second_len] = item.symbol;
          second_len = second_len + 1;
        end else begin
          dropped = 1'b1;
        end
      end
      ede_pkg::OP_COMPUTE: begin
        res.distance = edit_cost();
        res.overflow = dropped;
        expected_results.push_back(res);
        first_len = 0;
        second_len = 0;
        dropped = 1'b0;
      end
      default: begin
        // unused op, nothing changes
      end
    endcase
  endtask

  // sender: track what was taken at this edge, then offer the next item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_item(in_data);
      // a stalled item stays put; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall, plus one long hold on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) hold_left = hold_left - 1;
    out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < recv_stall_pct);
  end

  // result checker: compare each taken result with the oldest expectation
  always @(posedge clk) begin
    ede_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result item expected=none distance=%0d overflow=%0b",
                 $time, out_data.distance, out_data.overflow);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = expected_results.pop_front();
        if (out_data.distance !== want.distance) begin
          $display("%0t: distance mismatch expected=%0d actual=%0d",
                   $time, want.distance, out_data.distance);
          mismatch_count = mismatch_count + 1;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch expected=%0b actual=%0b",
                   $time, want.overflow, out_data.overflow);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  task automatic push_item(input logic [ede_pkg::OP_W-1:0] op,
                           input logic [ede_pkg::SYM_W-1:0] sym);
    ede_pkg::in_item_t item;
    item.op = op;
    item.symbol = sym;
    pending_items.push_back(item);
    if (op != OP_UNUSED) loaded_count = loaded_count + 1;
  endtask

  // one load-and-compute sequence; an alphabet that is often narrow makes matches likely
  task automatic queue_job(input int unsigned len_a, input int unsigned len_b);
    int unsigned left_a;
    int unsigned left_b;
    int unsigned span;
    logic [ede_pkg::SYM_W-1:0] base;
    left_a = len_a;
    left_b = len_b;
    base = ede_pkg::SYM_W'($urandom);
    case ($urandom_range(0, 3))
      0: span = 2;
      1: span = 4;
      2: span = 16;
      default: span = 256;
    endcase
    while (left_a + left_b > 0) begin
      // stray unused ops mixed into the loads
      if ($urandom_range(0, 99) < 3) push_item(OP_UNUSED, ede_pkg::SYM_W'($urandom));
      if (left_b == 0 || (left_a != 0 && $urandom_range(0, 1) == 1)) begin
        push_item(ede_pkg::OP_APPEND_FIRST,
                  ede_pkg::SYM_W'(base + $urandom_range(0, span - 1)));
        left_a = left_a - 1;
      end else begin
        push_item(ede_pkg::OP_APPEND_SECOND,
                  ede_pkg::SYM_W'(base + $urandom_range(0, span - 1)));
        left_b = left_b - 1;
      end
    end
    push_item(ede_pkg::OP_COMPUTE, ede_pkg::SYM_W'($urandom));
  endtask

  // mostly short strings, some empty, a few near, at or past the full length
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return $urandom_range(MAX_LEN - 8, MAX_LEN + 6);
    if (r < 12) return 0;
    return $urandom_range(1, 12);
  endfunction

  task automatic fill_random(input int unsigned target);
    while (loaded_count < target) queue_job(pick_len(), pick_len());
  endtask

  // wait until everything is offered, taken and answered, then let loads settle
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // phase one: sender idles now and then, receiver mostly stalls
    send_idle_pct = 27;
    recv_stall_pct = 85;

    // both strings empty
    push_item(ede_pkg::OP_COMPUTE, 8'h00);
    // second string empty, extreme symbols
    push_item(ede_pkg::OP_APPEND_FIRST, 8'h00);
    push_item(ede_pkg::OP_APPEND_FIRST, 8'hff);
    push_item(ede_pkg::OP_COMPUTE, 8'hff);
    // first string empty
    push_item(ede_pkg::OP_APPEND_SECOND, 8'hff);
    push_item(ede_pkg::OP_APPEND_SECOND, 8'h00);
    push_item(ede_pkg::OP_APPEND_SECOND, 8'h55);
    push_item(ede_pkg::OP_COMPUTE, 8'haa);
    // swapped pair, with an unused op in between that must change nothing
    push_item(ede_pkg::OP_APPEND_FIRST, 8'haa);
    push_item(ede_pkg::OP_APPEND_FIRST, 8'h55);
    push_item(ede_pkg::OP_APPEND_SECOND, 8'h55);
    push_item(OP_UNUSED, 8'hff);
    push_item(ede_pkg::OP_APPEND_SECOND, 8'haa);
    push_item(ede_pkg::OP_COMPUTE, 8'h00);
    // identical one-byte strings
    push_item(ede_pkg::OP_APPEND_FIRST, 8'h01);
    push_item(ede_pkg::OP_APPEND_SECOND, 8'h01);
    push_item(ede_pkg::OP_COMPUTE, 8'h7f);
    // compute right after a compute, nothing loaded in between
    push_item(ede_pkg::OP_COMPUTE, 8'h80);

    // full strings: drops past the end on each side, then both full
    queue_job(MAX_LEN + 2, 0);
    queue_job(0, MAX_LEN + 3);
    queue_job(MAX_LEN, MAX_LEN);
    fill_random(ITEMS_PER_PHASE);
    wait_drained();

    // phase two: sender mostly idle, receiver stalls now and then
    send_idle_pct = 85;
    recv_stall_pct = 27;
    fill_random(2 * ITEMS_PER_PHASE);
    wait_drained();

    // phase three: no idling, with one long receiver hold up front so that
    // the output backs up and the input stalls behind it
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fill_random(3 * ITEMS_PER_PHASE);
    hold_request = 1'b1;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("edit_distance_engine_top verification clean");
    end else begin
      $display("edit_distance_engine_top verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #16_000_000;
    $display("edit_distance_engine_top verification failed");
    $finish;
  end

endmodule

/* sim.f */
design/ede_pkg.sv
design/ede_ctrl.sv
design/ede_datapath.sv
design/edit_distance_engine_top.sv
tb/sv/edit_distance_engine_top_test.sv
